/* design/pkd_pkg.sv */
// ----------------------------------------------------------------------------
// pkd_pkg - PS/2 key event decoder shared types
// Command format between front and back, prefix states, sequencer states and
// the scan code to key number tables.
// ----------------------------------------------------------------------------
`default_nettype none

package pkd_pkg;

  localparam int KEY_ID_W = 7;

  localparam logic [7:0] BREAK_CODE = 8'hF0;
  localparam logic [7:0] EXT_CODE   = 8'hE0;
  localparam logic [7:0] NULL_CODE  = 8'h00;

  typedef enum logic [1:0] {
    PFX_NONE      = 2'd0,
    PFX_BREAK     = 2'd1,
    PFX_EXT       = 2'd2,
    PFX_EXT_BREAK = 2'd3
  } prefix_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SHIFT,
    ST_DONE
  } back_state_t;

  // One classified key code
  typedef struct packed {
    logic       ext;
    logic       rel;
    logic [7:0] code;
  } cmd_t;

  function automatic logic [KEY_ID_W-1:0] map_normal(input logic [7:0] code);
    logic [KEY_ID_W-1:0] id;
    unique case (code)
      8'h76: id = 7'd1;   8'h05: id = 7'd2;   8'h06: id = 7'd3;   8'h04: id = 7'd4;
      8'h0C: id = 7'd5;   8'h03: id = 7'd6;   8'h0B: id = 7'd7;   8'h83: id = 7'd8;
      8'h0A: id = 7'd9;   8'h01: id = 7'd10;  8'h09: id = 7'd11;  8'h78: id = 7'd12;
      8'h07: id = 7'd13;  8'h0E: id = 7'd14;  8'h16: id = 7'd15;  8'h1E: id = 7'd16;
      8'h26: id = 7'd17;  8'h25: id = 7'd18;  8'h2E: id = 7'd19;  8'h36: id = 7'd20;
      8'h3D: id = 7'd21;  8'h3E: id = 7'd22;  8'h46: id = 7'd23;  8'h45: id = 7'd24;
      8'h4E: id = 7'd25;  8'h55: id = 7'd26;  8'h66: id = 7'd27;  8'h0D: id = 7'd28;
      8'h15: id = 7'd29;  8'h1D: id = 7'd30;  8'h24: id = 7'd31;  8'h2D: id = 7'd32;
      8'h2C: id = 7'd33;  8'h35: id = 7'd34;  8'h3C: id = 7'd35;  8'h43: id = 7'd36;
      8'h44: id = 7'd37;  8'h4D: id = 7'd38;  8'h54: id = 7'd39;  8'h5B: id = 7'd40;
      8'h5D: id = 7'd41;  8'h58: id = 7'd42;  8'h1C: id = 7'd43;  8'h1B: id = 7'd44;
      8'h23: id = 7'd45;  8'h2B: id = 7'd46;  8'h34: id = 7'd47;  8'h33: id = 7'd48;
      8'h3B: id = 7'd49;  8'h42: id = 7'd50;  8'h4B: id = 7'd51;  8'h4C: id = 7'd52;
      8'h52: id = 7'd53;  8'h5A: id = 7'd54;  8'h12: id = 7'd55;  8'h1A: id = 7'd56;
      8'h22: id = 7'd57;  8'h21: id = 7'd58;  8'h2A: id = 7'd59;  8'h32: id = 7'd60;
      8'h31: id = 7'd61;  8'h3A: id = 7'd62;  8'h41: id = 7'd63;  8'h49: id = 7'd64;
      8'h4A: id = 7'd65;  8'h59: id = 7'd66;  8'h14: id = 7'd67;  8'h11: id = 7'd69;
      8'h29: id = 7'd70;
      default: id = '0;
    endcase
    return id;
  endfunction

  function automatic logic [KEY_ID_W-1:0] map_extended(input logic [7:0] code);
    logic [KEY_ID_W-1:0] id;
    unique case (code)
      8'h1F: id = 7'd68;  8'h11: id = 7'd71;  8'h14: id = 7'd72;  8'h75: id = 7'd73;
      8'h72: id = 7'd74;  8'h6B: id = 7'd75;  8'h74: id = 7'd76;  8'h70: id = 7'd77;
      8'h71: id = 7'd78;  8'h6C: id = 7'd79;  8'h69: id = 7'd80;  8'h7D: id = 7'd81;
      8'h7A: id = 7'd82;
      default: id = '0;
    endcase
    return id;
  endfunction

endpackage

`default_nettype wire

/* design/pkd_if.sv */
// ----------------------------------------------------------------------------
// pkd_if - PS/2 key event decoder stream interfaces
// Byte stream from the keyboard receiver and key event stream to the host.
// ----------------------------------------------------------------------------
`default_nettype none

interface pkd_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] scan_byte;

  modport source (output valid, output scan_byte, input ready);
  modport sink   (input valid, input scan_byte, output ready);
endinterface

interface pkd_event_if;
  logic       valid;
  logic       ready;
  logic [6:0] key_id;
  logic       key_down;
  logic       list_overflow;

  modport source (output valid, output key_id, output key_down, output list_overflow,
                  input ready);
  modport sink   (input valid, input key_id, input key_down, input list_overflow,
                  output ready);
endinterface

`default_nettype wire

/* design/pkd_front.sv */
// ----------------------------------------------------------------------------
// pkd_front - prefix tracking and byte classification
// Folds break/extended prefix bytes into the following code and hands one
// command per key code to the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module pkd_front import pkd_pkg::*; (
  input  wire logic   clk,
  input  wire logic   rst,
  pkd_byte_if.sink    scan,
  output logic        cmd_valid,
  output cmd_t        cmd,
  input  wire logic   cmd_ready
);

  prefix_t prefix, prefix_next;
  logic    is_cmd;
  logic    accept;

  assign scan.ready = cmd_ready;
  assign accept     = scan.valid && scan.ready;
  assign cmd_valid  = scan.valid && is_cmd;

  always_ff @(posedge clk) begin
    if (rst) begin
      prefix <= PFX_NONE;
    end else if (accept) begin
      prefix <= prefix_next;
    end
  end

  always_comb begin
    prefix_next = PFX_NONE;
    is_cmd      = 1'b1;
    cmd.code    = scan.scan_byte;
    cmd.ext     = 1'b0;
    cmd.rel     = 1'b0;
    unique case (prefix)
      PFX_NONE: begin
        if (scan.scan_byte == BREAK_CODE) begin
          prefix_next = PFX_BREAK;
          is_cmd      = 1'b0;
        end else if (scan.scan_byte == EXT_CODE) begin
          prefix_next = PFX_EXT;
          is_cmd      = 1'b0;
        end else if (scan.scan_byte == NULL_CODE) begin
          is_cmd      = 1'b0;
        end
      end
      PFX_BREAK: begin
        cmd.rel = 1'b1;
      end
      PFX_EXT: begin
        cmd.ext = 1'b1;
        if (scan.scan_byte == BREAK_CODE) begin
          prefix_next = PFX_EXT_BREAK;
          is_cmd      = 1'b0;
        end
      end
      PFX_EXT_BREAK: begin
        cmd.ext = 1'b1;
        cmd.rel = 1'b1;
      end
      default: begin
        is_cmd = 1'b0;
      end
    endcase
  end

endmodule

`default_nettype wire

/* design/pkd_queue.sv */
// ----------------------------------------------------------------------------
// pkd_queue - two-entry command queue
// Decouples byte intake from the held-list sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module pkd_queue import pkd_pkg::*; (
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire logic   in_valid,
  input  wire cmd_t   in_cmd,
  output logic        in_ready,
  output logic        out_valid,
  output cmd_t        out_cmd,
  input  wire logic   out_ready
);

  cmd_t       entries [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fill;
  logic       push;
  logic       pop;

  assign in_ready  = (fill != 2'd2);
  assign out_valid = (fill != 2'd0);
  assign out_cmd   = entries[rd_ptr];
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop)  rd_ptr <= !rd_ptr;
      if (push && !pop) begin
        fill <= fill + 2'd1;
      end else if (pop && !push) begin
        fill <= fill - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= in_cmd;
  end

endmodule

`default_nettype wire

/* design/pkd_back.sv */
// ----------------------------------------------------------------------------
// pkd_back - held-key list sequencer
// Walks the held list of the command's kind one entry per cycle, closes the
// gap on a release, appends on a new press while the list has room and registers the key event.
// ----------------------------------------------------------------------------
`default_nettype none

module pkd_back import pkd_pkg::*; #(
  parameter int HELD_KEYS = 8
) (
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire logic   cmd_valid,
  input  wire cmd_t   cmd,
  output logic        cmd_ready,
  pkd_event_if.source key_ev
);

  localparam int CW = $clog2(HELD_KEYS + 1);
  localparam int IW = (HELD_KEYS > 1) ? $clog2(HELD_KEYS) : 1;
  localparam logic [CW-1:0] FULL = CW'(HELD_KEYS);

  back_state_t state, state_next;
  cmd_t        cur;
  logic [CW-1:0] idx, idx_next, idx_p1;
  logic          found, found_next;

  logic [7:0]    norm_list [HELD_KEYS];
  logic [7:0]    ext_list  [HELD_KEYS];
  logic [CW-1:0] norm_count;
  logic [CW-1:0] ext_count;

  logic [CW-1:0] sel_count;
  logic [7:0]    rd_entry;
  logic [7:0]    rd_next;

  logic          wr_en;
  logic [IW-1:0] wr_idx;
  logic [7:0]    wr_data;
  logic          cnt_inc;
  logic          cnt_dec;

  logic          slot_free;
  logic          load_out;
  logic          ovf;
  logic          out_valid;
  logic [KEY_ID_W-1:0] out_id;
  logic          out_down;
  logic          out_ovf;

  assign idx_p1    = idx + CW'(1);
  assign sel_count = cur.ext ? ext_count : norm_count;
  assign rd_entry  = cur.ext ? ext_list[idx[IW-1:0]] : norm_list[idx[IW-1:0]];
  assign rd_next   = cur.ext ? ext_list[idx_p1[IW-1:0]] : norm_list[idx_p1[IW-1:0]];
  assign slot_free = !out_valid || key_ev.ready;

  assign key_ev.valid         = out_valid;
  assign key_ev.key_id        = out_id;
  assign key_ev.key_down      = out_down;
  assign key_ev.list_overflow = out_ovf;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      idx        <= '0;
      found      <= 1'b0;
      norm_count <= '0;
      ext_count  <= '0;
      out_valid  <= 1'b0;
    end else begin
      state <= state_next;
      idx   <= idx_next;
      found <= found_next;
      if (cnt_inc) begin
        if (cur.ext) ext_count  <= ext_count + CW'(1);
        else         norm_count <= norm_count + CW'(1);
      end else if (cnt_dec) begin
        if (cur.ext) ext_count  <= ext_count - CW'(1);
        else         norm_count <= norm_count - CW'(1);
      end
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (key_ev.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_valid && cmd_ready) cur <= cmd;
    if (wr_en) begin
      if (cur.ext) ext_list[wr_idx]  <= wr_data;
      else         norm_list[wr_idx] <= wr_data;
    end
    if (load_out) begin
      out_id   <= cur.ext ? map_extended(cur.code) : map_normal(cur.code);
      out_down <= !cur.rel;
      out_ovf  <= ovf;
    end
  end

  always_comb begin
    state_next = state;
    idx_next   = idx;
    found_next = found;
    cmd_ready  = 1'b0;
    wr_en      = 1'b0;
    wr_idx     = idx[IW-1:0];
    wr_data    = rd_next;
    cnt_inc    = 1'b0;
    cnt_dec    = 1'b0;
    load_out   = 1'b0;
    ovf        = 1'b0;
    unique case (state)
      ST_IDLE: begin
        cmd_ready = 1'b1;
        if (cmd_valid) begin
          state_next = ST_SCAN;
          idx_next   = '0;
          found_next = 1'b0;
        end
      end
      ST_SCAN: begin
        if (idx == sel_count) begin
          state_next = ST_DONE;
        end else if (rd_entry == cur.code) begin
          found_next = 1'b1;
          state_next = cur.rel ? ST_SHIFT : ST_DONE;
        end else begin
          idx_next = idx_p1;
        end
      end
      ST_SHIFT: begin
        // move the tail down one slot, then drop the last entry
        if (idx_p1 < sel_count) begin
          wr_en    = 1'b1;
          idx_next = idx_p1;
        end else begin
          cnt_dec    = 1'b1;
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!cur.rel && found) begin
          state_next = ST_IDLE;       // auto-repeat, nothing to report
        end else if (slot_free) begin
          load_out   = 1'b1;
          state_next = ST_IDLE;
          if (!cur.rel) begin
            if (sel_count < FULL) begin
              wr_en   = 1'b1;
              wr_idx  = sel_count[IW-1:0];
              wr_data = cur.code;
              cnt_inc = 1'b1;
            end else begin
              ovf = 1'b1;
            end
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

/* design/ps2_key_event_decoder.sv */
// ----------------------------------------------------------------------------
// ps2_key_event_decoder - PS/2 scan code set 2 key event decoder
// Turns received keyboard bytes into key-down / key-up events, suppressing
// auto-repeat with per-kind lists of held keys.
// ----------------------------------------------------------------------------
//  channel  dir  payload                              beat when
//  scan     in   scan_byte[7:0]                       scan.valid & scan.ready
//  key_ev   out  key_id[6:0] key_down list_overflow   key_ev.valid & key_ev.ready
//
//  The front takes a byte per cycle while the two-entry queue has room.
//  The back handles one key code at a time: it takes it while idle, walks the
//  list one entry per cycle, on release runs a shift pass over the entries
//  past the hit, and reports in its done state.
//  Event output is registered; a stalled output holds the back in its last
//  step while the front keeps filling the queue.
//  Synchronous reset empties the queue, both held lists and the prefix.
// ----------------------------------------------------------------------------
`default_nettype none

module ps2_key_event_decoder import pkd_pkg::*; #(
  parameter int HELD_KEYS = 8
) (
  input  wire logic   clk,
  input  wire logic   rst,
  pkd_byte_if.sink    scan,
  pkd_event_if.source key_ev
);

  logic f_valid, f_ready;
  cmd_t f_cmd;
  logic b_valid, b_ready;
  cmd_t b_cmd;

  pkd_front u_front (
    .clk       (clk),
    .rst       (rst),
    .scan      (scan),
    .cmd_valid (f_valid),
    .cmd       (f_cmd),
    .cmd_ready (f_ready)
  );

  pkd_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (f_valid),
    .in_cmd    (f_cmd),
    .in_ready  (f_ready),
    .out_valid (b_valid),
    .out_cmd   (b_cmd),
    .out_ready (b_ready)
  );

  pkd_back #(
    .HELD_KEYS (HELD_KEYS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (b_valid),
    .cmd       (b_cmd),
    .cmd_ready (b_ready),
    .key_ev    (key_ev)
  );

endmodule

`default_nettype wire

/* test/tb.sv */
// ----------------------------------------------------------------------------
// tb - regression bench for ps2_key_event_decoder
// Feeds PS/2 set 2 byte streams through the scan channel and checks every key
// event against a local model of the prefix state and the two held-key lists.
// Directed cases cover the prefixes, the zero byte, repeats, stray releases
// and full lists; random typing and line noise with random stalls follow.
// ----------------------------------------------------------------------------
module tb;
  import pkd_pkg::*;

  localparam int HELD         = 8;
  localparam int DRAIN_CYCLES = 2 * HELD + 3 + 40;
  localparam int CYCLE_LIMIT  = 800_000;

  // key number n <-> normal code NORMAL_CODES[n]; entries 0 and 68 are unused
  localparam logic [7:0] NORMAL_CODES [71] = '{
    8'h00,
    8'h76, 8'h05, 8'h06, 8'h04, 8'h0C, 8'h03, 8'h0B, 8'h83, 8'h0A, 8'h01, 8'h09, 8'h78,
    8'h07, 8'h0E, 8'h16, 8'h1E, 8'h26, 8'h25, 8'h2E, 8'h36, 8'h3D, 8'h3E, 8'h46, 8'h45,
    8'h4E, 8'h55, 8'h66, 8'h0D, 8'h15, 8'h1D, 8'h24, 8'h2D, 8'h2C, 8'h35, 8'h3C, 8'h43,
    8'h44, 8'h4D, 8'h54, 8'h5B, 8'h5D, 8'h58, 8'h1C, 8'h1B, 8'h23, 8'h2B, 8'h34, 8'h33,
    8'h3B, 8'h42, 8'h4B, 8'h4C, 8'h52, 8'h5A, 8'h12, 8'h1A, 8'h22, 8'h21, 8'h2A, 8'h32,
    8'h31, 8'h3A, 8'h41, 8'h49, 8'h4A, 8'h59, 8'h14, 8'h00, 8'h11, 8'h29
  };
  localparam logic [7:0] EXT_CODES [13] = '{
    8'h1F, 8'h11, 8'h14, 8'h75, 8'h72, 8'h6B, 8'h74, 8'h70, 8'h71, 8'h6C, 8'h69, 8'h7D, 8'h7A
  };
  localparam logic [6:0] EXT_IDS [13] = '{
    7'd68, 7'd71, 7'd72, 7'd73, 7'd74, 7'd75, 7'd76, 7'd77, 7'd78, 7'd79, 7'd80, 7'd81,
    7'd82
  };

  typedef struct packed {
    logic [6:0] key_id;
    logic       key_down;
    logic       list_overflow;
  } key_event_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  pkd_byte_if  scan_bus ();
  pkd_event_if event_bus ();

  ps2_key_event_decoder #(.HELD_KEYS(HELD)) DUT (
    .clk    (clk),
    .rst    (rst),
    .scan   (scan_bus),
    .key_ev (event_bus)
  );

  always #1 clk = ~clk;

  // decoder model state; list 0 holds normal codes, list 1 extended codes
  prefix_t    pfx = PFX_NONE;
  logic [7:0] held_codes [2][HELD];
  int         held_cnt [2] = '{0, 0};

  key_event_t pending_events [$];
  key_event_t got_ev, want_ev;

  int  errors = 0;
  int  cycles = 0;
  int  n_bytes = 0;
  int  n_checked = 0;
  int  n_press = 0;
  int  n_release = 0;
  int  n_overflow = 0;
  int  n_repeat = 0;
  int  ready_left = 0;
  bit  quiet_io = 1'b0;

  // ---------------------------------------------------------------- model --

  function automatic logic [6:0] key_number(input int ext, input logic [7:0] code);
    int i;
    if (ext != 0) begin
      for (i = 0; i < 13; i++)
        if (EXT_CODES[i] == code) return EXT_IDS[i];
    end else begin
      for (i = 0; i < 71; i++)
        if (NORMAL_CODES[i] == code) return i[6:0];
    end
    return 7'd0;
  endfunction

  function automatic int find_held(input int k, input logic [7:0] code);
    int i;
    for (i = 0; i < held_cnt[k]; i++)
      if (held_codes[k][i] == code) return i;
    return held_cnt[k];
  endfunction

  task automatic record_press(input int k, input logic [7:0] code);
    logic ovf;
    if (find_held(k, code) < held_cnt[k]) begin
      n_repeat++;  // auto-repeat: swallowed
      return;
    end
    ovf = (held_cnt[k] >= HELD);
    if (!ovf) begin
      held_codes[k][held_cnt[k]] = code;
      held_cnt[k]++;
    end
    pending_events.push_back('{key_id: key_number(k, code), key_down: 1'b1,
                               list_overflow: ovf});
    n_press++;
    if (ovf) n_overflow++;
  endtask

  task automatic record_release(input int k, input logic [7:0] code);
    int pos, j;
    pos = find_held(k, code);
    if (pos < held_cnt[k]) begin
      for (j = pos + 1; j < held_cnt[k]; j++) held_codes[k][j-1] = held_codes[k][j];
      held_cnt[k]--;
    end
    pending_events.push_back('{key_id: key_number(k, code), key_down: 1'b0,
                               list_overflow: 1'b0});
    n_release++;
  endtask

  task automatic decode_byte(input logic [7:0] b);
    case (pfx)
      PFX_BREAK: begin
        pfx = PFX_NONE;
        record_release(0, b);
      end
      PFX_EXT_BREAK: begin
        pfx = PFX_NONE;
        record_release(1, b);
      end
      PFX_EXT: begin
        if (b == BREAK_CODE) begin
          pfx = PFX_EXT_BREAK;
        end else begin
          pfx = PFX_NONE;
          record_press(1, b);
        end
      end
      default: begin
        if (b == BREAK_CODE) pfx = PFX_BREAK;
        else if (b == EXT_CODE) pfx = PFX_EXT;
        else if (b != NULL_CODE) record_press(0, b);
      end
    endcase
  endtask

  // --------------------------------------------------------- stimulus side --

  // mostly no gap, some short ones, a few long
  function automatic int idle_len();
    int r;
    if (quiet_io) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // valid stays up across back-to-back beats; it is only lowered for a gap
  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = idle_len();
    if (gap > 0) begin
      scan_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    scan_bus.valid     <= 1'b1;
    scan_bus.scan_byte <= b;
    @(posedge clk);
    while (!scan_bus.ready) @(posedge clk);
    decode_byte(b);
    n_bytes++;
  endtask

  task automatic send_key(input int ext, input bit rel, input logic [7:0] code);
    if (ext != 0) send_byte(EXT_CODE);
    if (rel) send_byte(BREAK_CODE);
    send_byte(code);
  endtask

  task automatic release_all(input int k);
    while (held_cnt[k] > 0)
      send_key(k, 1'b1, held_codes[k][$urandom_range(0, held_cnt[k] - 1)]);
  endtask

  function automatic logic [7:0] table_code(input int k);
    int i;
    if (k != 0) return EXT_CODES[$urandom_range(0, 12)];
    i = $urandom_range(1, 70);
    if (i == 68) i = 69;  // slot 68 has no normal code
    return NORMAL_CODES[i];
  endfunction

  // ------------------------------------------------------------------ tests --

  task automatic test_prefix_and_null();
    send_byte(NULL_CODE);                   // ignored with no prefix
    send_key(1, 1'b1, NULL_CODE);           // code bytes after a prefix are
    send_key(0, 1'b1, NULL_CODE);           // taken whatever their value
    send_key(0, 1'b1, EXT_CODE);
    send_key(0, 1'b1, BREAK_CODE);
    send_key(1, 1'b0, EXT_CODE);
    send_key(1, 1'b1, EXT_CODE);
  endtask

  task automatic test_repeat_and_stray_release();
    send_key(0, 1'b0, 8'h83);
    send_key(0, 1'b0, 8'h83);               // repeat, no event
    send_key(0, 1'b1, 8'h83);
    send_key(0, 1'b1, 8'h76);               // not held
    send_key(1, 1'b0, 8'h7A);
    send_key(1, 1'b1, 8'h7D);               // extended, not held
  endtask

  task automatic test_list_full();
    int k, i;
    for (k = 0; k < 2; k++) begin
      for (i = 0; i < HELD + 2; i++)
        send_key(k, 1'b0, (k != 0) ? EXT_CODES[i] : NORMAL_CODES[i + 1]);
      // free a middle entry, the next new press must be recorded again
      send_key(k, 1'b1, held_codes[k][HELD / 2]);
      send_key(k, 1'b0, (k != 0) ? EXT_CODES[HELD + 2] : NORMAL_CODES[HELD + 3]);
      send_key(k, 1'b0, (k != 0) ? EXT_CODES[HELD + 3] : NORMAL_CODES[HELD + 4]);
      release_all(k);
    end
  endtask

  task automatic test_typing(input int target);
    int k, r;
    while (n_bytes < target) begin
      if (n_bytes % 100 == 0) quiet_io = ($urandom_range(0, 4) == 0);
      k = ($urandom_range(0, 99) < 35) ? 1 : 0;
      r = $urandom_range(0, 99);
      if (r < 45) send_key(k, 1'b0, table_code(k));
      else if (r < 60 && held_cnt[k] > 0)
        send_key(k, 1'b0, held_codes[k][$urandom_range(0, held_cnt[k] - 1)]);
      else if (r < 85 && held_cnt[k] > 0)
        send_key(k, 1'b1, held_codes[k][$urandom_range(0, held_cnt[k] - 1)]);
      else if (r < 90) send_key(k, 1'b1, table_code(k));
      else if (r < 96) send_key(k, 1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
      else release_all(k);
    end
    quiet_io = 1'b0;
  endtask

  // raw bytes, dangling prefixes and broken sequences mixed with real keys
  task automatic test_line_noise(input int target);
    int r, k;
    while (n_bytes < target) begin
      r = $urandom_range(0, 99);
      k = $urandom_range(0, 1);
      if (r < 40) send_byte(8'($urandom_range(0, 255)));
      else if (r < 50) send_byte(BREAK_CODE);
      else if (r < 60) send_byte(EXT_CODE);
      else send_key(k, 1'($urandom_range(0, 1)), table_code(k));
    end
  endtask

  // ---------------------------------------------------------------- checks --

  // result sink: random stretches of ready, with stalls of random length
  always @(posedge clk) begin
    if (ready_left > 0) begin
      ready_left--;
    end else if (quiet_io) begin
      event_bus.ready <= 1'b1;
    end else if ($urandom_range(0, 2) != 0) begin
      event_bus.ready <= 1'b1;
      ready_left = $urandom_range(0, 12);
    end else begin
      event_bus.ready <= 1'b0;
      ready_left = idle_len();
    end
  end

  always @(posedge clk) begin
    if (!rst && event_bus.valid && event_bus.ready) begin
      got_ev = {event_bus.key_id, event_bus.key_down, event_bus.list_overflow};
      if (pending_events.size() == 0) begin
        errors++;
        $display("%0t: unexpected event id=%0d down=%0b ovf=%0b", $time,
                 got_ev.key_id, got_ev.key_down, got_ev.list_overflow);
      end else begin
        want_ev = pending_events.pop_front();
        n_checked++;
        if (got_ev !== want_ev) begin
          errors++;
          $display("%0t: event mismatch, expected id=%0d down=%0b ovf=%0b,",
                   $time, want_ev.key_id, want_ev.key_down, want_ev.list_overflow);
          $display("    got id=%0d down=%0b ovf=%0b",
                   got_ev.key_id, got_ev.key_down, got_ev.list_overflow);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t: timeout, %0d events still expected", $time, pending_events.size());
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    scan_bus.valid     = 1'b0;
    scan_bus.scan_byte = 8'h00;
    event_bus.ready    = 1'b0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    test_prefix_and_null();
    test_repeat_and_stray_release();
    test_list_full();
    test_typing(1350);
    test_line_noise(1650);

    scan_bus.valid <= 1'b0;
    quiet_io = 1'b1;
    while (pending_events.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("sent %0d bytes, checked %0d events: %0d presses (%0d on a full list),",
             n_bytes, n_checked, n_press, n_overflow);
    $display("%0d releases, %0d auto-repeats swallowed, %0d mismatches",
             n_release, n_repeat, errors);
    if (errors == 0 && pending_events.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
